// File: hdl/correlating_branch_predictor_defines.svh
// assertion macros used by the predictor module
`ifndef CORRELATING_BRANCH_PREDICTOR_DEFINES_SVH
`define CORRELATING_BRANCH_PREDICTOR_DEFINES_SVH

// checked on every rising edge outside reset
`define CBP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every rising edge, reset included
`define CBP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hdl/cbp_pkg.sv
package cbp_pkg;

  // default sizes of history, address index and counters
  localparam int MAX_HISTORY_BITS_DEF = 4;
  localparam int MAX_INDEX_BITS_DEF   = 8;
  localparam int MAX_COUNTER_BITS_DEF = 4;

  // fixed field widths
  localparam int ADDR_W       = 32;
  localparam int COUNT_W      = 32;
  localparam int ENTRIES_W    = 13;
  localparam int HIST_CFG_W   = 3;
  localparam int CTR_CFG_W    = 3;
  localparam int INDEX_CFG_W  = 4;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 4;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_HISTORY_BITS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COUNTER_BITS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INDEX_BITS   = 2'd2;

  // flags from the counter update logic
  typedef struct packed {
    logic pred;
    logic miss;
    logic first_touch;
  } cbp_upd_flags_t;

endpackage

// File: hdl/cbp_ram.sv
module cbp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read, old data on a same-address write
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: hdl/cbp_ctr_update.sv
module cbp_ctr_update
  import cbp_pkg::*;
#(
  parameter int MAX_COUNTER_BITS = MAX_COUNTER_BITS_DEF
) (
  input  logic [CTR_CFG_W-1:0]      counter_bits,
  input  logic [MAX_COUNTER_BITS:0] word_in,
  input  logic                      taken,
  output logic [MAX_COUNTER_BITS:0] word_out,
  output cbp_upd_flags_t            flags
);

  logic [3:0]                  n_eff;
  logic [MAX_COUNTER_BITS-1:0] full;
  logic [MAX_COUNTER_BITS-1:0] top;
  logic [MAX_COUNTER_BITS-1:0] ctr;
  logic [MAX_COUNTER_BITS-1:0] step;
  logic [MAX_COUNTER_BITS-1:0] ctr_nxt;
  logic                        valid_in;
  logic                        pred;
  logic                        miss;

  // effective counter width, clamped to one and the maximum
  always_comb begin
    if (counter_bits == '0) begin
      n_eff = 4'd1;
    end else if ({1'b0, counter_bits} > 4'(MAX_COUNTER_BITS)) begin
      n_eff = 4'(MAX_COUNTER_BITS);
    end else begin
      n_eff = {1'b0, counter_bits};
    end
  end

  // width mask and top bit
  always_comb begin
    for (int i = 0; i < MAX_COUNTER_BITS; i++) begin
      full[i] = (4'(i) < n_eff);
      top[i]  = (4'(i) == (n_eff - 4'd1));
    end
  end

  // untouched entries read as zero
  assign valid_in = word_in[MAX_COUNTER_BITS];
  assign ctr      = valid_in ? (word_in[MAX_COUNTER_BITS-1:0] & full) : '0;
  assign pred     = |(ctr & top);
  assign miss     = (pred != taken);

  // hit drives to the extreme, miss steps and jumps on a top bit flip
  always_comb begin
    step = taken ? (ctr + 1'b1) : (ctr - 1'b1);
    if (!miss) begin
      ctr_nxt = taken ? full : '0;
    end else if (taken) begin
      ctr_nxt = (|(step & top)) ? full : step;
    end else begin
      ctr_nxt = (|(step & top)) ? step : '0;
    end
  end

  assign word_out          = {1'b1, ctr_nxt & full};
  assign flags.pred        = pred;
  assign flags.miss        = miss;
  assign flags.first_touch = !valid_in;

endmodule

// File: hdl/correlating_branch_predictor.sv
// correlating (m,n) branch predictor
// in channel: in_valid/in_stall with in_branch_address and in_taken, one resolved
//   branch per transfer. out channel: out_valid/out_stall with the prediction,
//   the miss flag and the running miss, branch and touched-entry counts.
// cfg channel: cfg_valid/cfg_ready, cfg_index selects history_bits (0),
//   counter_bits (1) or index_bits (2); other indexes are ignored. Write only
//   while no branch is in flight.
// path: an accepted branch waits in the update stage, then moves into the output
//   register as soon as that register frees up.
// throughput: one branch per cycle while out_stall is low. The counter memory is
//   read the cycle a branch is taken in and written back when it leaves the
//   update stage; a branch hitting the entry being written gets the word forwarded.
// when the receiver stalls, the result holds in the output register and one more
//   branch may still enter; after that in_stall rises until out_stall drops.
// reset: counts, history and configuration go to their reset values, then a
//   clearing pass zeroes the counter memory one entry a cycle, all
//   2^(MAX_HISTORY_BITS+MAX_INDEX_BITS) entries (4096 at defaults), with
//   in_stall high. Configuration writes are taken during the pass.
module correlating_branch_predictor
  import cbp_pkg::*;
#(
  parameter int MAX_HISTORY_BITS = MAX_HISTORY_BITS_DEF,
  parameter int MAX_INDEX_BITS   = MAX_INDEX_BITS_DEF,
  parameter int MAX_COUNTER_BITS = MAX_COUNTER_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [ADDR_W-1:0]     in_branch_address,
  input  logic                  in_taken,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_predicted_taken,
  output logic                  out_mispredict,
  output logic [COUNT_W-1:0]    out_miss_count,
  output logic [COUNT_W-1:0]    out_branch_count,
  output logic [ENTRIES_W-1:0]  out_entries_used,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  `include "correlating_branch_predictor_defines.svh"

  localparam int IDX_W  = MAX_HISTORY_BITS + MAX_INDEX_BITS;
  localparam int DEPTH  = 1 << IDX_W;
  localparam int USED_W = IDX_W + 1;
  localparam int WORD_W = MAX_COUNTER_BITS + 1;
  localparam logic [USED_W-1:0] USED_MAX = USED_W'(1) << IDX_W;

  // configuration registers
  logic [HIST_CFG_W-1:0]  history_bits_r;
  logic [CTR_CFG_W-1:0]   counter_bits_r;
  logic [INDEX_CFG_W-1:0] index_bits_r;

  // front end
  logic [MAX_HISTORY_BITS-1:0] hist_r;
  logic [3:0]                  m_eff;
  logic [3:0]                  b_eff;
  logic [MAX_HISTORY_BITS-1:0] hmask;
  logic [MAX_INDEX_BITS-1:0]   amask;
  logic [IDX_W-1:0]            rd_idx;
  logic                        in_xfer;

  // clearing pass
  logic             clearing_r;
  logic [IDX_W-1:0] clr_idx_r;

  // update stage
  logic              s1_valid_r;
  logic [IDX_W-1:0]  s1_idx_r;
  logic              s1_taken_r;
  logic              byp_r;
  logic [WORD_W-1:0] byp_word_r;
  logic [WORD_W-1:0] ram_rdata;
  logic [WORD_W-1:0] cur_word;
  logic [WORD_W-1:0] new_word;
  cbp_upd_flags_t    upd;
  logic              s1_adv;

  // memory write port
  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  logic [WORD_W-1:0] ram_wdata;

  // statistics
  logic [COUNT_W-1:0] misses_r,   misses_nxt;
  logic [COUNT_W-1:0] branches_r, branches_nxt;
  logic [USED_W-1:0]  used_r,     used_nxt;
  logic [USED_W+ENTRIES_W-1:0] used_ext;

  // output register
  logic                 out_valid_r;
  logic                 out_pred_r;
  logic                 out_miss_r;
  logic [COUNT_W-1:0]   out_misses_r;
  logic [COUNT_W-1:0]   out_branches_r;
  logic [ENTRIES_W-1:0] out_used_r;

  // configuration writes
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      history_bits_r <= HIST_CFG_W'(2);
      counter_bits_r <= CTR_CFG_W'(2);
      index_bits_r   <= INDEX_CFG_W'(8);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_HISTORY_BITS: history_bits_r <= cfg_wdata[HIST_CFG_W-1:0];
        REG_COUNTER_BITS: counter_bits_r <= cfg_wdata[CTR_CFG_W-1:0];
        REG_INDEX_BITS:   index_bits_r   <= cfg_wdata[INDEX_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // handshake: the update stage moves on when the output register frees up
  assign s1_adv   = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = clearing_r || (s1_valid_r && !s1_adv);
  assign in_xfer  = in_valid && !in_stall;

  // clamped history and address widths
  always_comb begin
    m_eff = ({1'b0, history_bits_r} > 4'(MAX_HISTORY_BITS)) ?
            4'(MAX_HISTORY_BITS) : {1'b0, history_bits_r};
    b_eff = (index_bits_r > 4'(MAX_INDEX_BITS)) ? 4'(MAX_INDEX_BITS) : index_bits_r;
    for (int i = 0; i < MAX_HISTORY_BITS; i++) begin
      hmask[i] = (4'(i) < m_eff);
    end
    for (int j = 0; j < MAX_INDEX_BITS; j++) begin
      amask[j] = (4'(j) < b_eff);
    end
  end

  assign rd_idx = {hist_r & hmask, in_branch_address[MAX_INDEX_BITS-1:0] & amask};

  // global history shifts on every input transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist_r <= '0;
    end else if (in_xfer) begin
      hist_r <= MAX_HISTORY_BITS'({hist_r, in_taken});
    end
  end

  // clearing pass after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_idx_r  <= '0;
    end else if (clearing_r) begin
      clr_idx_r <= clr_idx_r + 1'b1;
      if (clr_idx_r == {IDX_W{1'b1}}) begin
        clearing_r <= 1'b0;
      end
    end
  end

  // write port: clearing pass or update write-back
  assign ram_we    = clearing_r || s1_adv;
  assign ram_waddr = clearing_r ? clr_idx_r : s1_idx_r;
  assign ram_wdata = clearing_r ? '0 : new_word;

  cbp_ram #(
    .WIDTH (WORD_W),
    .DEPTH (DEPTH)
  ) u_ctr_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (in_xfer),
    .raddr (rd_idx),
    .rdata (ram_rdata)
  );

  // update stage registers, forwarding a write to the entry just read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_xfer) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_idx_r   <= rd_idx;
      s1_taken_r <= in_taken;
      byp_r      <= s1_adv && (s1_idx_r == rd_idx);
      byp_word_r <= new_word;
    end
  end

  assign cur_word = byp_r ? byp_word_r : ram_rdata;

  cbp_ctr_update #(
    .MAX_COUNTER_BITS (MAX_COUNTER_BITS)
  ) u_ctr_update (
    .counter_bits (counter_bits_r),
    .word_in      (cur_word),
    .taken        (s1_taken_r),
    .word_out     (new_word),
    .flags        (upd)
  );

  // saturating statistics
  always_comb begin
    misses_nxt   = misses_r;
    branches_nxt = branches_r;
    used_nxt     = used_r;
    if (upd.miss && (misses_r != '1)) begin
      misses_nxt = misses_r + 1'b1;
    end
    if (branches_r != '1) begin
      branches_nxt = branches_r + 1'b1;
    end
    if (upd.first_touch && (used_r < USED_MAX)) begin
      used_nxt = used_r + 1'b1;
    end
  end

  assign used_ext = {{ENTRIES_W{1'b0}}, used_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      misses_r   <= '0;
      branches_r <= '0;
      used_r     <= '0;
    end else if (s1_adv) begin
      misses_r   <= misses_nxt;
      branches_r <= branches_nxt;
      used_r     <= used_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_pred_r     <= upd.pred;
      out_miss_r     <= upd.miss;
      out_misses_r   <= misses_nxt;
      out_branches_r <= branches_nxt;
      out_used_r     <= used_ext[ENTRIES_W-1:0];
    end
  end

  assign out_valid           = out_valid_r;
  assign out_predicted_taken = out_pred_r;
  assign out_mispredict      = out_miss_r;
  assign out_miss_count      = out_misses_r;
  assign out_branch_count    = out_branches_r;
  assign out_entries_used    = out_used_r;

  // checks
  `CBP_ASSERT(a_adv_fills_out, s1_adv |=> out_valid_r, "update did not reach output")
  `CBP_ASSERT(a_branch_step, (s1_adv && (branches_r != '1)) |=> (branches_r == $past(branches_r) + 1'b1), "branch count did not step")
  `CBP_ASSERT(a_used_bound, used_r <= USED_MAX, "touched entries above table depth")
  `CBP_ASSERT(a_no_work_in_clear, !(clearing_r && s1_valid_r), "branch in flight during clearing pass")
  `CBP_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> (clearing_r && !s1_valid_r && !out_valid_r), "pipeline not idle after reset")

endmodule
